[src/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape block: request and
// result words, the job word that travels from front end to back end, and
// the result kind and error codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Depth of the job queue between front end and back end
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNTERM    = 3'd1;
  localparam logic [2:0] ERR_CTRL      = 3'd2;
  localparam logic [2:0] ERR_ESC_UNTRM = 3'd3;
  localparam logic [2:0] ERR_ESC_UNKN  = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd5;
  localparam logic [2:0] ERR_NO_LOW    = 3'd6;
  localparam logic [2:0] ERR_LONE_LOW  = 3'd7;

  // One input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
    logic       at_end;
  } req_t;

  // One result
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;
  } res_t;

  // Work for the back end: one code point (or raw byte) and its result count
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [20:0] cp;
    logic [1:0]  nres;   // number of results minus one
  } job_t;

  // Queue status seen by the front end and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[src/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Short job queue between the front end and the back end. Push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jsu_pkg::job_t     din,
  input  logic              pop,
  output jsu_pkg::job_t     dout,
  output jsu_pkg::q_status_t status
);
  import jsu_pkg::*;

  job_t           slots [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QCw-1:0] count;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAw'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAw'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign dout         = slots[rd_ptr];
  assign status.full  = (count == QCw'(QDepth));
  assign status.empty = (count == '0);

endmodule

[src/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Front end: takes one request per cycle unless the queue is full, runs the
// string scanner and turns each request that yields output into one job.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  jsu_pkg::req_t      req,
  input  jsu_pkg::q_status_t q_status,
  output logic               push,
  output jsu_pkg::job_t      job
);
  import jsu_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_STR     = 7'b0000010,
    S_ESC     = 7'b0000100,
    S_HEX1    = 7'b0001000,
    S_WANT_BS = 7'b0010000,
    S_WANT_U  = 7'b0100000,
    S_HEX2    = 7'b1000000
  } scan_state_t;

  localparam logic [7:0]  ChQuote = 8'h22;
  localparam logic [7:0]  ChBslash = 8'h5C;
  localparam logic [7:0]  ChSlash = 8'h2F;
  localparam logic [7:0]  ChSpace = 8'h20;
  localparam logic [7:0]  ChU = 8'h75;
  localparam logic [5:0]  HighTag = 6'b110110;
  localparam logic [5:0]  LowTag = 6'b110111;
  localparam logic [20:0] Plane1 = 21'h10000;

  scan_state_t state, state_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [9:0]  high_half, high_half_next;

  logic        accept;
  logic        job_valid;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] acc_shift;
  logic [20:0] pair_cp;

  // Decode one ASCII hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic job_t err_job(input logic [2:0] code);
    job_t j;
    j = '{kind: KIND_ERROR, error_code: code, cp: '0, nres: '0};
    return j;
  endfunction

  function automatic job_t byte_job(input logic [7:0] b);
    job_t j;
    j = '{kind: KIND_DATA, error_code: ERR_NONE, cp: {13'd0, b}, nres: '0};
    return j;
  endfunction

  // UTF-8 encoding length of a code point, minus one
  function automatic job_t utf8_job(input logic [20:0] cp);
    job_t j;
    j = '{kind: KIND_DATA, error_code: ERR_NONE, cp: cp, nres: 2'd3};
    if (cp < 21'h80) begin
      j.nres = 2'd0;
    end else if (cp < 21'h800) begin
      j.nres = 2'd1;
    end else if (cp < 21'h10000) begin
      j.nres = 2'd2;
    end
    return j;
  endfunction

  assign accept    = req_valid && !q_status.full;
  assign req_stall = q_status.full;
  assign {hex_ok, hex_val} = hex_decode(req.in_byte);
  assign acc_shift = {hex_accum[11:0], hex_val};
  assign pair_cp   = Plane1 + {1'b0, high_half, acc_shift[9:0]};

  // Scanner next state and job
  always_comb begin
    state_next     = state;
    hex_count_next = hex_count;
    hex_accum_next = hex_accum;
    high_half_next = high_half;
    job_valid      = 1'b0;
    job            = '{kind: KIND_DATA, error_code: ERR_NONE, cp: '0, nres: '0};
    if (req.at_end) begin
      state_next = S_IDLE;
      unique case (state)
        S_STR: begin
          job_valid = 1'b1;
          job       = err_job(ERR_UNTERM);
        end
        S_ESC: begin
          job_valid = 1'b1;
          job       = err_job(ERR_ESC_UNTRM);
        end
        S_HEX1, S_HEX2: begin
          job_valid = 1'b1;
          job       = err_job(ERR_BAD_HEX);
        end
        S_WANT_BS, S_WANT_U: begin
          job_valid = 1'b1;
          job       = err_job(ERR_NO_LOW);
        end
        default: ;
      endcase
    end else if (req.start_req) begin
      state_next     = S_STR;
      hex_count_next = '0;
      hex_accum_next = '0;
      high_half_next = '0;
    end else begin
      unique case (state)
        S_STR: begin
          job_valid = 1'b1;
          if (req.in_byte == ChQuote) begin
            state_next = S_IDLE;
            job        = '{kind: KIND_CLOSE, error_code: ERR_NONE, cp: '0, nres: '0};
          end else if (req.in_byte < ChSpace) begin
            state_next = S_IDLE;
            job        = err_job(ERR_CTRL);
          end else if (req.in_byte == ChBslash) begin
            state_next = S_ESC;
            job_valid  = 1'b0;
          end else begin
            job = byte_job(req.in_byte);
          end
        end
        S_ESC: begin
          state_next = S_STR;
          job_valid  = 1'b1;
          case (req.in_byte)
            ChQuote, ChBslash, ChSlash: job = byte_job(req.in_byte);
            8'h62: job = byte_job(8'h08);
            8'h66: job = byte_job(8'h0C);
            8'h6E: job = byte_job(8'h0A);
            8'h72: job = byte_job(8'h0D);
            8'h74: job = byte_job(8'h09);
            ChU: begin
              state_next     = S_HEX1;
              hex_count_next = '0;
              hex_accum_next = '0;
              job_valid      = 1'b0;
            end
            default: begin
              state_next = S_IDLE;
              job        = err_job(ERR_ESC_UNKN);
            end
          endcase
        end
        S_HEX1, S_HEX2: begin
          if (!hex_ok) begin
            state_next = S_IDLE;
            job_valid  = 1'b1;
            job        = err_job(ERR_BAD_HEX);
          end else begin
            hex_accum_next = acc_shift;
            if (hex_count == 2'd3) begin
              hex_count_next = '0;
              if (state == S_HEX1) begin
                if (acc_shift[15:10] == HighTag) begin
                  high_half_next = acc_shift[9:0];
                  state_next     = S_WANT_BS;
                end else if (acc_shift[15:10] == LowTag) begin
                  state_next = S_IDLE;
                  job_valid  = 1'b1;
                  job        = err_job(ERR_LONE_LOW);
                end else begin
                  state_next = S_STR;
                  job_valid  = 1'b1;
                  job        = utf8_job({5'd0, acc_shift});
                end
              end else begin
                job_valid = 1'b1;
                if (acc_shift[15:10] != LowTag) begin
                  state_next = S_IDLE;
                  job        = err_job(ERR_NO_LOW);
                end else begin
                  state_next = S_STR;
                  job        = utf8_job(pair_cp);
                end
              end
            end else begin
              hex_count_next = hex_count + 1'b1;
            end
          end
        end
        S_WANT_BS: begin
          if (req.in_byte == ChBslash) begin
            state_next = S_WANT_U;
          end else begin
            state_next = S_IDLE;
            job_valid  = 1'b1;
            job        = err_job(ERR_NO_LOW);
          end
        end
        S_WANT_U: begin
          if (req.in_byte == ChU) begin
            state_next     = S_HEX2;
            hex_count_next = '0;
            hex_accum_next = '0;
          end else begin
            state_next = S_IDLE;
            job_valid  = 1'b1;
            job        = err_job(ERR_NO_LOW);
          end
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  assign push = accept && job_valid;

  // Update scanner state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hex_count <= '0;
      hex_accum <= '0;
      high_half <= '0;
    end else if (accept) begin
      state     <= state_next;
      hex_count <= hex_count_next;
      hex_accum <= hex_accum_next;
      high_half <= high_half_next;
    end
  end

endmodule

[src/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Back end: takes queued jobs and drives their results, one per cycle while
// not stalled, through the output register. Code points become UTF-8 bytes here.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk,
  input  logic               rst,
  input  jsu_pkg::job_t      head,
  input  jsu_pkg::q_status_t q_status,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output jsu_pkg::res_t      res
);
  import jsu_pkg::*;

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;

  logic [1:0] idx;
  logic       load;
  logic       last_one;
  logic [7:0] byte_out;
  logic [1:0] remain;
  logic [5:0] six;

  assign load     = !res_valid || !res_stall;
  assign last_one = (idx == head.nres);
  assign pop      = load && !q_status.empty && last_one;
  assign remain   = head.nres - idx;

  // Pick the six payload bits of a continuation byte
  always_comb begin
    case (remain)
      2'd0:    six = head.cp[5:0];
      2'd1:    six = head.cp[11:6];
      default: six = head.cp[17:12];
    endcase
  end

  // Form the byte for position idx of the current job
  always_comb begin
    byte_out = {2'b10, six};
    if (head.nres == 2'd0) begin
      byte_out = head.cp[7:0];
    end else if (idx == 2'd0) begin
      case (head.nres)
        2'd1:    byte_out = LeadTwo | {3'd0, head.cp[10:6]};
        2'd2:    byte_out = LeadThree | {4'd0, head.cp[15:12]};
        default: byte_out = LeadFour | {5'd0, head.cp[20:18]};
      endcase
    end
  end

  // Walk through the results of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= !q_status.empty;
      if (!q_status.empty) begin
        idx <= last_one ? 2'd0 : idx + 1'b1;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load && !q_status.empty) begin
      res.out_byte   <= byte_out;
      res.kind       <= head.kind;
      res.error_code <= head.error_code;
      res.last       <= last_one;
    end
  end

endmodule

[src/json_string_unescape_utf8_top.sv]
// Decodes the body of a JSON string literal one byte per request: a start
// request carries the opening quote, plain bytes pass through, escapes turn
// into their characters and \u escapes (with surrogate pairs joined) into
// one to four UTF-8 bytes; the closing quote gives a close result and any
// fault gives one error result, after which the block waits for the next
// start request. Requests are taken at one per cycle while the queue is not
// full. Each request that yields output becomes one job in a four-entry
// queue, and the back end drives the job's results one at a time through
// its output register; the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// Top level: front-end scanner, job queue and UTF-8 back end.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  jsu_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output jsu_pkg::res_t res
);
  import jsu_pkg::*;

  job_t      push_job;
  job_t      head_job;
  logic      push;
  logic      pop;
  q_status_t q_status;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .job       (push_job)
  );

  jsu_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (push_job),
    .pop    (pop),
    .dout   (head_job),
    .status (q_status)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // Close and error results always end their request
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == KIND_CLOSE || res.kind == KIND_ERROR) |-> res.last)
    else $error("close or error result without last");

  // Data and close results carry no error code, errors always carry one
  a_code_matches_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.kind == KIND_ERROR) == (res.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // Only the three defined kinds appear
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.kind == KIND_DATA || res.kind == KIND_CLOSE ||
                   res.kind == KIND_ERROR))
    else $error("undefined result kind");

endmodule
